[rtl/wmh_pkg.sv]
// package for the window mismatch histogram
// widths, register indexes and shared types; no dependencies

package wmh_pkg;

    localparam int DEF_WINDOW_MAX  = 32;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int OUT_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int GUIDE_WORDS = 4;
    localparam int WORD_CHARS  = CFG_DATA_W / BYTE_W;
    localparam int GUIDE_CHARS = GUIDE_WORDS * WORD_CHARS;
    localparam int GIDX_W      = $clog2(GUIDE_CHARS);
    localparam int BINS        = 6;

    localparam logic [LEN_W-1:0] WIN_LEN_RST = LEN_W'(32);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GUIDE_0   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GUIDE_1   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GUIDE_2   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_GUIDE_3   = CFG_IDX_W'(4);

    typedef logic [GUIDE_CHARS-1:0][BYTE_W-1:0] t_guide;

    // counter bank update for one window
    typedef struct packed {
        logic            go;
        logic            last;
        logic [BINS-1:0] hit;
    } t_hist_upd;

endpackage

[rtl/wmh_if.sv]
// channel interfaces for the window mismatch histogram
// depends on wmh_pkg

interface wmh_in_if import wmh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] base;
    logic              last;

    modport source (output valid, output base, output last, input ready);
    modport sink   (input valid, input base, input last, output ready);
endinterface

interface wmh_out_if import wmh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] exact_hits;
    logic [OUT_W-1:0] one_mismatch_hits;
    logic [OUT_W-1:0] two_mismatch_hits;
    logic [OUT_W-1:0] three_mismatch_hits;
    logic [OUT_W-1:0] four_mismatch_hits;
    logic [OUT_W-1:0] five_mismatch_hits;

    modport source (output valid, output exact_hits, output one_mismatch_hits,
                    output two_mismatch_hits, output three_mismatch_hits,
                    output four_mismatch_hits, output five_mismatch_hits,
                    input ready);
    modport sink   (input valid, input exact_hits, input one_mismatch_hits,
                    input two_mismatch_hits, input three_mismatch_hits,
                    input four_mismatch_hits, input five_mismatch_hits,
                    output ready);
endinterface

interface wmh_cfg_if import wmh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/wmh_match.sv]
// per-position compare of the window against the right-aligned guide
// depends on wmh_pkg

module wmh_match import wmh_pkg::*; #(
    parameter int WINDOW_MAX = DEF_WINDOW_MAX
) (
    input  logic [WINDOW_MAX-1:0][BYTE_W-1:0] i_window,
    input  t_guide                            i_guide,
    input  logic [LEN_W-1:0]                  i_len,
    output logic [WINDOW_MAX-1:0]             o_mm
);

    // window entry j (newest at 0) lines up with guide char len-1-j
    always_comb begin
        logic [LEN_W-1:0] v_idx;
        v_idx = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            v_idx   = i_len - LEN_W'(j) - LEN_W'(1);
            o_mm[j] = (LEN_W'(j) < i_len) &&
                      (i_window[j] != i_guide[v_idx[GIDX_W-1:0]]);
        end
    end

endmodule

[rtl/wmh_hist.sv]
// bank of saturating mismatch-bin counters, cleared at the end of a pass
// depends on wmh_pkg

module wmh_hist import wmh_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_hist_upd              i_upd,
    output logic [COUNT_WIDTH-1:0] o_next [BINS]
);

    logic [COUNT_WIDTH-1:0] r_cnt [BINS];

    always_comb begin
        for (int k = 0; k < BINS; k++) begin
            if (i_upd.hit[k] && (r_cnt[k] != '1)) begin
                o_next[k] = r_cnt[k] + COUNT_WIDTH'(1);
            end else begin
                o_next[k] = r_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BINS; k++) r_cnt[k] <= '0;
        end else if (i_upd.go) begin
            for (int k = 0; k < BINS; k++) begin
                r_cnt[k] <= i_upd.last ? '0 : o_next[k];
            end
        end
    end

    // a saturated counter never wraps to zero without a pass end
    generate
        for (genvar g = 0; g < BINS; g++) begin : g_chk
            a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_cnt[g] == '1) && !(i_upd.go && i_upd.last) |=> (r_cnt[g] == '1))
                else $error("hit counter wrapped");
        end
    endgenerate

endmodule

[rtl/window_mismatch_histogram.sv]
// window mismatch histogram, top level; depends on wmh_pkg, wmh_if, wmh_match, wmh_hist
// a last request passes through stages a, b and c and then loads the result register
// throughput: one request per cycle, the whole window is compared in parallel;
//   a last request waits in the final stage while the result is not taken,
//   and the requests behind it back up
// reset (synchronous, active low): window length 32, guide chars 0, fill 0, counters 0

module window_mismatch_histogram import wmh_pkg::*; #(
    parameter int WINDOW_MAX  = DEF_WINDOW_MAX,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wmh_cfg_if.sink   i_cfg,
    wmh_in_if.sink    i_in,
    wmh_out_if.source o_out
);

    // configuration registers
    logic [LEN_W-1:0] r_win_len;
    t_guide           r_guide;
    logic [LEN_W-1:0] len_eff;

    // window shift register, newest byte in entry 0, plus fill count
    logic [WINDOW_MAX-1:0][BYTE_W-1:0] r_window;
    logic [LEN_W-1:0]                  r_fill;
    logic [LEN_W-1:0]                  n_fill;

    // stage a: the window itself is the payload
    logic r_a_valid, r_a_en, r_a_last;
    // stage b: mismatch bit per position
    logic                  r_b_valid, r_b_en, r_b_last;
    logic [WINDOW_MAX-1:0] r_b_mm;
    logic [WINDOW_MAX-1:0] mm;
    // stage c: one-hot bin, empty when more than five mismatches or when no window ends
    logic            r_c_valid, r_c_last;
    logic [BINS-1:0] r_c_hit;
    logic [BINS-1:0] n_c_hit;

    // result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out [BINS];

    logic                   accept, out_free, c_go, c_ready, b_ready, a_ready;
    logic                   win_en;
    logic [COUNT_WIDTH-1:0] cnt_next [BINS];
    logic [OUT_W-1:0]       cnt_cap  [BINS];
    t_hist_upd              hist_upd;

    // ---------------- configuration port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_LEN_RST;
            r_guide   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WIN_LEN: r_win_len <= i_cfg.data[LEN_W-1:0];
                CFG_GUIDE_0: r_guide[0*WORD_CHARS +: WORD_CHARS] <= i_cfg.data;
                CFG_GUIDE_1: r_guide[1*WORD_CHARS +: WORD_CHARS] <= i_cfg.data;
                CFG_GUIDE_2: r_guide[2*WORD_CHARS +: WORD_CHARS] <= i_cfg.data;
                CFG_GUIDE_3: r_guide[3*WORD_CHARS +: WORD_CHARS] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // zero length acts as one, anything past the window as the window
    always_comb begin
        if (r_win_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_win_len > LEN_W'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = r_win_len;
        end
    end

    // ---------------- flow control ----------------
    // only a last request needs the result register; others stall only behind a waiting last request
    assign out_free = !r_out_valid || o_out.ready;
    assign c_go     = r_c_valid && (!r_c_last || out_free);
    assign c_ready  = !r_c_valid || c_go;
    assign b_ready  = !r_b_valid || c_ready;
    assign a_ready  = !r_a_valid || b_ready;

    assign i_in.ready = a_ready;
    assign accept     = i_in.valid && a_ready;

    // ---------------- window and fill ----------------
    always_comb begin
        n_fill = (r_fill < LEN_W'(WINDOW_MAX)) ? r_fill + LEN_W'(1) : r_fill;
    end
    // a window ends once this pass has filled the current length
    assign win_en = (n_fill >= len_eff);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window[0] <= i_in.base;
            for (int j = 1; j < WINDOW_MAX; j++) r_window[j] <= r_window[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= i_in.last ? '0 : n_fill;
        end
    end

    // ---------------- stage a ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_en   <= win_en;
            r_a_last <= i_in.last;
        end
    end

    // ---------------- stage b: compare ----------------
    wmh_match #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_match (
        .i_window (r_window),
        .i_guide  (r_guide),
        .i_len    (len_eff),
        .o_mm     (mm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && b_ready) begin
            r_b_mm   <= mm;
            r_b_en   <= r_a_en;
            r_b_last <= r_a_last;
        end
    end

    // ---------------- stage c: mismatch count to bin ----------------
    always_comb begin
        for (int k = 0; k < BINS; k++) begin
            n_c_hit[k] = r_b_en && ($countones(r_b_mm) == k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && c_ready) begin
            r_c_hit  <= n_c_hit;
            r_c_last <= r_b_last;
        end
    end

    // ---------------- counters ----------------
    assign hist_upd.go   = c_go;
    assign hist_upd.last = r_c_last;
    assign hist_upd.hit  = r_c_hit;

    wmh_hist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (hist_upd),
        .o_next  (cnt_next)
    );

    // wide counters report at most all ones on the 32-bit fields
    generate
        if (COUNT_WIDTH > OUT_W) begin : g_cap
            always_comb begin
                for (int k = 0; k < BINS; k++) begin
                    cnt_cap[k] = (|cnt_next[k][COUNT_WIDTH-1:OUT_W]) ? '1
                                 : cnt_next[k][OUT_W-1:0];
                end
            end
        end else begin : g_ext
            always_comb begin
                for (int k = 0; k < BINS; k++) cnt_cap[k] = OUT_W'(cnt_next[k]);
            end
        end
    endgenerate

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_go && r_c_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_go && r_c_last) begin
            for (int k = 0; k < BINS; k++) r_out[k] <= cnt_cap[k];
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.exact_hits          = r_out[0];
    assign o_out.one_mismatch_hits   = r_out[1];
    assign o_out.two_mismatch_hits   = r_out[2];
    assign o_out.three_mismatch_hits = r_out[3];
    assign o_out.four_mismatch_hits  = r_out[4];
    assign o_out.five_mismatch_hits  = r_out[5];

    // ---------------- checks ----------------
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(WINDOW_MAX))
        else $error("window fill past window size");

    a_last_clears_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last |=> (r_fill == '0))
        else $error("fill not cleared after last request");

    a_bin_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> $onehot0(r_c_hit))
        else $error("more than one bin hit");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_go && r_c_last |=> r_out_valid)
        else $error("end of pass did not load the result");

endmodule

[tb/tb.sv]
// self-checking testbench for window_mismatch_histogram
// drives the reference byte stream and guide registers, predicts each histogram
// depends on wmh_pkg, wmh_if and the top level of the block

module tb import wmh_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_MAX  = DEF_WINDOW_MAX;
    localparam int DRAIN_CYCLES = 8;
    localparam int TARGET_BYTES = 600;
    localparam int HOLD_CYCLES  = 250;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_GUIDE_3 + 1'b1;
    localparam logic [31:0] NUCLEOTIDES = "ACGT";

    typedef logic [BINS-1:0][OUT_W-1:0] t_hist;

    // one pending reference byte with the idle cycles that go before it
    typedef struct {
        logic [BYTE_W-1:0] base;
        logic              last;
        int unsigned       gap;
    } t_ref_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wmh_cfg_if cfg_ch ();
    wmh_in_if  in_ch ();
    wmh_out_if out_ch ();

    window_mismatch_histogram dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mirror of the block: guide registers, window, fill and the six bins
    logic [LEN_W-1:0]                      win_len_q;
    logic [GUIDE_WORDS-1:0][CFG_DATA_W-1:0] guide_word_q;
    logic [BYTE_W-1:0]                     window_q [WINDOW_MAX];
    int unsigned                           fill_q;
    t_hist                                 bins_q;

    t_hist    hist_expect [$];   // histograms still owed by the block
    t_ref_req ref_pending [$];   // bytes waiting for the driver

    // idle knobs, changed only while the block is quiet
    int unsigned in_gap_max  = 0;
    int unsigned out_gap_max = 0;
    logic        holding     = 1'b0;
    event        hold_kick;

    // driver state
    t_ref_req    staged;
    logic        staged_ok = 1'b0;
    int unsigned staged_wait = 0;
    int unsigned out_wait = 0;

    // bookkeeping
    int unsigned errors = 0;
    int unsigned queued_bytes = 0;
    int unsigned bytes_taken = 0;
    int unsigned hists_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned phases = 0;
    int unsigned bin_seen [BINS];

    string bin_name [BINS] = '{"exact_hits", "one_mismatch_hits", "two_mismatch_hits",
                               "three_mismatch_hits", "four_mismatch_hits",
                               "five_mismatch_hits"};

    // a length of 0 behaves as 1, anything past the window size as the window size
    function automatic int unsigned window_len();
        if (win_len_q == 0)
            return 1;
        if (win_len_q > WINDOW_MAX)
            return WINDOW_MAX;
        return 32'(win_len_q);
    endfunction

    function automatic logic [BYTE_W-1:0] guide_byte(int unsigned pos);
        return guide_word_q[pos / WORD_CHARS][(pos % WORD_CHARS) * BYTE_W +: BYTE_W];
    endfunction

    // shift one byte in, score the window it closes, emit on the last byte
    function automatic void absorb_base(logic [BYTE_W-1:0] b, logic is_last);
        int unsigned n;
        int unsigned mism;
        n = window_len();
        for (int i = WINDOW_MAX - 1; i > 0; i--)
            window_q[i] = window_q[i-1];
        window_q[0] = b;
        if (fill_q < WINDOW_MAX)
            fill_q++;
        if (fill_q >= n) begin
            mism = 0;
            // oldest byte of the window lines up with guide character 0
            for (int i = 0; i < n; i++)
                if (window_q[n-1-i] != guide_byte(i))
                    mism++;
            if (mism < BINS && bins_q[mism] != '1)
                bins_q[mism]++;
        end
        if (is_last) begin
            hist_expect.push_back(bins_q);
            bins_q = '0;
            fill_q = 0;
        end
    endfunction

    function automatic int unsigned draw_gap(int unsigned gmax);
        if (gmax == 0 || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(1, gmax);
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        if ($urandom_range(0, 1))
            return NUCLEOTIDES[BYTE_W * $urandom_range(0, 3) +: BYTE_W];
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_guide_word();
        logic [CFG_DATA_W-1:0] w;
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            2: w = {$urandom, $urandom};
            default: begin
                for (int i = 0; i < WORD_CHARS; i++)
                    w[i*BYTE_W +: BYTE_W] = NUCLEOTIDES[BYTE_W * $urandom_range(0, 3) +: BYTE_W];
            end
        endcase
        return w;
    endfunction

    task automatic queue_base(logic [BYTE_W-1:0] b, logic is_last);
        t_ref_req r;
        r.base = b;
        r.last = is_last;
        r.gap  = draw_gap(in_gap_max);
        ref_pending.push_back(r);
        queued_bytes++;
    endtask

    // a pass made mostly of guide copies with a few bytes flipped, plus some noise;
    // close marks its final byte as last, otherwise the pass stays open
    task automatic queue_pass(int unsigned target, logic close);
        int unsigned n;
        int unsigned count;
        int unsigned p;
        logic [BYTE_W-1:0] seg [WINDOW_MAX];
        n = window_len();
        count = 0;
        while (count < target) begin
            if ($urandom_range(0, 3) != 0) begin
                for (int i = 0; i < n; i++)
                    seg[i] = guide_byte(i);
                // up to six flips, so every bin and the overflow case show up
                repeat ($urandom_range(0, 6)) begin
                    p = $urandom_range(0, n - 1);
                    seg[p] = seg[p] ^ BYTE_W'($urandom_range(1, 255));
                end
                for (int i = 0; i < n && count < target; i++) begin
                    queue_base(seg[i], close && count == target - 1);
                    count++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if (count < target) begin
                        queue_base(noise_byte(), close && count == target - 1);
                        count++;
                    end
                end
            end
        end
    endtask

    // one register write; the mirror takes it when the request is accepted
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_WIN_LEN: win_len_q = val[LEN_W-1:0];
            CFG_GUIDE_0: guide_word_q[0] = val;
            CFG_GUIDE_1: guide_word_q[1] = val;
            CFG_GUIDE_2: guide_word_q[2] = val;
            CFG_GUIDE_3: guide_word_q[3] = val;
            default: ;    // unused index, block ignores it
        endcase
    endtask

    // wait until every byte is in and every histogram is out, then let the
    // pipeline empty of bytes that owe nothing
    task automatic settle();
        while (ref_pending.size() != 0 || staged_ok || in_ch.valid || hist_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // byte driver: keeps valid up across back-to-back requests, holds on stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.base  <= '0;
            in_ch.last  <= 1'b0;
            staged_ok = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_base(in_ch.base, in_ch.last);
                bytes_taken++;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (!staged_ok && ref_pending.size() != 0) begin
                    staged = ref_pending.pop_front();
                    staged_ok = 1'b1;
                    staged_wait = staged.gap;
                end
                if (staged_ok && staged_wait == 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.base  <= staged.base;
                    in_ch.last  <= staged.last;
                    staged_ok = 1'b0;
                end else begin
                    in_ch.valid <= 1'b0;
                    if (staged_ok)
                        staged_wait--;
                end
            end
        end
    end

    // long receiver hold-off so the result register fills and stalls last bytes
    always begin
        @(hold_kick);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    // histogram monitor and checker
    always @(posedge i_clk) begin
        t_hist got;
        t_hist want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got[0] = out_ch.exact_hits;
                got[1] = out_ch.one_mismatch_hits;
                got[2] = out_ch.two_mismatch_hits;
                got[3] = out_ch.three_mismatch_hits;
                got[4] = out_ch.four_mismatch_hits;
                got[5] = out_ch.five_mismatch_hits;
                if (hist_expect.size() == 0) begin
                    $display("%0t: histogram with none expected, actual exact %0d one %0d",
                             $time, got[0], got[1]);
                    errors++;
                end else begin
                    want = hist_expect.pop_front();
                    hists_checked++;
                    for (int b = 0; b < BINS; b++) begin
                        if (got[b] != want[b]) begin
                            $display("%0t: %s expected %0d actual %0d",
                                     $time, bin_name[b], want[b], got[b]);
                            errors++;
                        end
                        if (want[b] != 0)
                            bin_seen[b]++;
                    end
                end
                out_wait = draw_gap(out_gap_max);
            end else if (out_wait > 0) begin
                out_wait--;
            end
            out_ch.ready <= !holding && out_wait == 0;
        end
    end

    initial begin
        #2_000_000;
        $display("%0t: timed out, %0d histograms still owed", $time, hist_expect.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [LEN_W-1:0] len;
        int unsigned n;

        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_WIN_LEN;
        cfg_ch.data  = '0;
        for (int b = 0; b < BINS; b++)
            bin_seen[b] = 0;

        // mirror starts from the block's reset values
        win_len_q    = WIN_LEN_RST;
        guide_word_q = '0;
        fill_q       = 0;
        bins_q       = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
            window_q[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // reset guide is 32 long, so two bytes make a short pass: all zeros
        queue_base(8'h00, 1'b0);
        queue_base(8'hFF, 1'b1);
        settle();

        // four-character guide "ACGT" with junk above it
        write_reg(CFG_WIN_LEN, CFG_DATA_W'(4));
        write_reg(CFG_GUIDE_0, {32'hA5C3_0FF0, "TGCA"});
        write_reg(CFG_GUIDE_1, '1);
        write_reg(CFG_GUIDE_2, '0);
        write_reg(CFG_GUIDE_3, {$urandom, $urandom});
        // unused indexes must leave the guide alone
        write_reg(CFG_UNUSED_LO, '1);
        write_reg('1, 64'h0123_4567_89AB_CDEF);

        // two exact windows with three shifted ones in between
        for (int i = 0; i < 8; i++)
            queue_base(NUCLEOTIDES[BYTE_W * (3 - (i % 4)) +: BYTE_W], i == 7);
        // one mismatch in the last position
        queue_base("A", 1'b0);
        queue_base("C", 1'b0);
        queue_base("G", 1'b0);
        queue_base("A", 1'b1);
        // single-byte pass, flagged byte alone
        queue_base("T", 1'b1);
        // pass left open across a length change: held bytes are reused
        queue_base("A", 1'b0);
        queue_base("C", 1'b0);
        settle();
        write_reg(CFG_WIN_LEN, CFG_DATA_W'(2));
        queue_base("G", 1'b1);
        settle();

        // zero length acts as one
        write_reg(CFG_WIN_LEN, '0);
        queue_base("A", 1'b0);
        queue_base(8'hFF, 1'b0);
        queue_base("A", 1'b1);
        settle();

        // ---- random part ----
        while (queued_bytes < TARGET_BYTES) begin
            phases++;
            case ($urandom_range(0, 3))
                0: begin in_gap_max = 0;  out_gap_max = 0;  end
                1: begin in_gap_max = 12; out_gap_max = 0;  end
                2: begin in_gap_max = 0;  out_gap_max = 12; end
                default: begin in_gap_max = 12; out_gap_max = 12; end
            endcase

            // extremes of the length, including out-of-range values, now and then
            case ($urandom_range(0, 9))
                0: len = LEN_W'(1);
                1: len = '0;
                2: len = LEN_W'(WINDOW_MAX);
                3: len = '1;
                4: len = LEN_W'(WINDOW_MAX + 1);
                5: len = LEN_W'(2);
                default: len = LEN_W'($urandom_range(3, 12));
            endcase
            write_reg(CFG_WIN_LEN, CFG_DATA_W'(len));
            if (phases == 1 || $urandom_range(0, 1)) write_reg(CFG_GUIDE_0, pick_guide_word());
            if (phases == 1 || $urandom_range(0, 1)) write_reg(CFG_GUIDE_1, pick_guide_word());
            if (phases == 1 || $urandom_range(0, 1)) write_reg(CFG_GUIDE_2, pick_guide_word());
            if (phases == 1 || $urandom_range(0, 1)) write_reg(CFG_GUIDE_3, pick_guide_word());
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, (1 << CFG_IDX_W) - 1)),
                          {$urandom, $urandom});

            if (phases == 3) begin
                // receiver stalls for a long stretch while short passes keep coming
                in_gap_max = 0;
                -> hold_kick;
                repeat (30) queue_pass($urandom_range(1, 3), 1'b1);
            end else begin
                n = window_len();
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 4) == 0)
                        queue_pass($urandom_range(1, n), 1'b1);
                    else
                        queue_pass(n + $urandom_range(0, 20), 1'b1);
                end
                // sometimes leave a pass open so the next setting lands mid-pass
                if ($urandom_range(0, 4) == 0)
                    queue_pass($urandom_range(1, n), 1'b0);
            end
            settle();
        end

        // close whatever pass is still open
        queue_base(noise_byte(), 1'b1);
        settle();

        $display("covered %0d bytes, %0d histograms, %0d register writes in %0d phases",
                 bytes_taken, hists_checked, reg_writes, phases);
        $display("histograms with nonzero bins 0..5: %0d %0d %0d %0d %0d %0d",
                 bin_seen[0], bin_seen[1], bin_seen[2], bin_seen[3], bin_seen[4], bin_seen[5]);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/wmh_pkg.sv
rtl/wmh_if.sv
rtl/wmh_match.sv
rtl/wmh_hist.sv
rtl/window_mismatch_histogram.sv
tb/tb.sv
